// ----- hdl/date_string_to_epoch_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the date string to epoch core.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_TO_EPOCH_CORE_MACROS_SVH
`define DATE_STRING_TO_EPOCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/dse_pkg.sv -----
// ----------------------------------------------------------------------------
// dse_pkg
// Types, constants and tables of the date string to epoch core.
// ----------------------------------------------------------------------------
package dse_pkg;

    localparam int POS_W        = 5;
    localparam int YEAR_W       = 14;
    localparam int FIELD_W      = 7;
    localparam int LETTERS_W    = 24;
    localparam int EPOCH_W      = 39;
    localparam int OFFSET_W     = 17;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 17;
    localparam int QUEUE_DEPTH  = 2;

    localparam int LEN_GMT      = 29;
    localparam int LEN_LOCAL    = 19;
    localparam int POS_MAX      = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UTC_OFFSET  = 1'd1;

    typedef enum logic [2:0] {
        ROLE_NONE   = 3'd0,
        ROLE_YEAR   = 3'd1,
        ROLE_MONTH  = 3'd2,
        ROLE_DAY    = 3'd3,
        ROLE_HOUR   = 3'd4,
        ROLE_MIN    = 3'd5,
        ROLE_SEC    = 3'd6,
        ROLE_LETTER = 3'd7
    } role_t;

    typedef struct packed {
        logic                 mode;
        logic                 len_ok;
        logic                 bad;
        logic [YEAR_W-1:0]    year;
        logic [FIELD_W-1:0]   month_val;
        logic [LETTERS_W-1:0] letters;
        logic [FIELD_W-1:0]   day;
        logic [FIELD_W-1:0]   hour;
        logic [FIELD_W-1:0]   minute;
        logic [FIELD_W-1:0]   second;
    } job_t;

    function automatic role_t role_of(input logic mode, input logic [POS_W-1:0] pos);
        role_t r;
        r = ROLE_NONE;
        if (mode)
        begin
            unique case (pos)
                5'd0, 5'd1, 5'd2, 5'd3: r = ROLE_YEAR;
                5'd5, 5'd6:             r = ROLE_MONTH;
                5'd8, 5'd9:             r = ROLE_DAY;
                5'd11, 5'd12:           r = ROLE_HOUR;
                5'd14, 5'd15:           r = ROLE_MIN;
                5'd17, 5'd18:           r = ROLE_SEC;
                default:                r = ROLE_NONE;
            endcase
        end
        else
        begin
            unique case (pos)
                5'd5, 5'd6:                 r = ROLE_DAY;
                5'd8, 5'd9, 5'd10:          r = ROLE_LETTER;
                5'd12, 5'd13, 5'd14, 5'd15: r = ROLE_YEAR;
                5'd17, 5'd18:               r = ROLE_HOUR;
                5'd20, 5'd21:               r = ROLE_MIN;
                5'd23, 5'd24:               r = ROLE_SEC;
                default:                    r = ROLE_NONE;
            endcase
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] days_in_month(input logic [3:0] m0);
        logic [FIELD_W-1:0] d;
        unique case (m0)
            4'd1:                    d = 7'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 7'd30;
            default:                 d = 7'd31;
        endcase
        return d;
    endfunction

    // Cumulative day offset of March-based month m, that is floor(367 * m / 12).
    function automatic logic [8:0] month_days_367(input logic [3:0] mm);
        logic [8:0] d;
        unique case (mm)
            4'd1:    d = 9'd30;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd152;
            4'd6:    d = 9'd183;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd305;
            4'd11:   d = 9'd336;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/date_string_to_epoch_core.sv -----
// ----------------------------------------------------------------------------
// date_string_to_epoch_core
// Date string to Unix seconds converter, fed one character per request.
// ----------------------------------------------------------------------------
// One character is taken every clock cycle while full is low. When the last
// character of a string arrives, its fields go into a two-entry queue, and a
// sequencer then takes each string through its steps in order (load, validation, leap
// check, two reciprocal divisions, day sum, the multiply by 86400, the
// time-of-day add and offset subtract, and the write to the result register). A
// well-formed string is at least 19 characters long, so the sequencer keeps
// pace with such strings and the input sustains one character per cycle.
// Shorter strings sent back to back, or a result left waiting on the output,
// fill the queue; full is high while the queue holds two strings, and it then
// holds off every character until the sequencer takes the next string.
module date_string_to_epoch_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic [7:0]                             char_byte,
    input  logic                                   is_last,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [dse_pkg::EPOCH_W-1:0]     epoch_seconds,
    output logic                                   valid_res,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dse_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [dse_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic                                 format_mode_reg;
    logic signed [dse_pkg::OFFSET_W-1:0]  utc_offset_reg;
    logic                                 accept;
    logic                                 q_push;
    logic                                 q_full;
    logic                                 q_pop;
    logic                                 q_empty;
    dse_pkg::job_t                        front_job;
    dse_pkg::job_t                        back_job;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= 1'b0;
            utc_offset_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dse_pkg::REG_FORMAT_MODE: format_mode_reg <= cfg_data[0];
                dse_pkg::REG_UTC_OFFSET:  utc_offset_reg  <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    dse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_byte   (char_byte),
        .is_last     (is_last),
        .format_mode (format_mode_reg),
        .q_push      (q_push),
        .q_data      (front_job)
    );

    dse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_job),
        .empty     (q_empty)
    );

    dse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (back_job),
        .q_pop         (q_pop),
        .utc_offset    (utc_offset_reg),
        .pop           (pop),
        .empty         (empty),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

endmodule

// ----- hdl/dse_queue.sv -----
// ----------------------------------------------------------------------------
// dse_queue
// Short register queue of parsed date strings between front and back.
// ----------------------------------------------------------------------------
module dse_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dse_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output dse_pkg::job_t pop_data,
    output logic          empty
);

    localparam int PTR_W = $clog2(dse_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dse_pkg::QUEUE_DEPTH + 1);

    dse_pkg::job_t    slot_reg [dse_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(dse_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(dse_pkg::QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/dse_front.sv -----
// ----------------------------------------------------------------------------
// dse_front
// Character intake: classifies each position and accumulates the fields.
// ----------------------------------------------------------------------------
module dse_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    char_byte,
    input  logic                          is_last,
    input  logic                          format_mode,
    output logic                          q_push,
    output dse_pkg::job_t                 q_data
);

    logic [dse_pkg::POS_W-1:0]     pos_reg;
    logic [dse_pkg::YEAR_W-1:0]    year_reg,    year_next;
    logic [dse_pkg::FIELD_W-1:0]   month_reg,   month_next;
    logic [dse_pkg::LETTERS_W-1:0] letters_reg, letters_next;
    logic [dse_pkg::FIELD_W-1:0]   day_reg,     day_next;
    logic [dse_pkg::FIELD_W-1:0]   hour_reg,    hour_next;
    logic [dse_pkg::FIELD_W-1:0]   minute_reg,  minute_next;
    logic [dse_pkg::FIELD_W-1:0]   second_reg,  second_next;
    logic                          bad_reg,     bad_next;
    dse_pkg::role_t                role;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic                          len_ok;

    function automatic logic [dse_pkg::FIELD_W-1:0] mac7(
        input logic [dse_pkg::FIELD_W-1:0] v,
        input logic [3:0]                  d
    );
        logic [10:0] t;
        t = 11'(v) * 11'd10 + 11'(d);
        return t[dse_pkg::FIELD_W-1:0];
    endfunction

    function automatic logic [dse_pkg::YEAR_W-1:0] mac14(
        input logic [dse_pkg::YEAR_W-1:0] v,
        input logic [3:0]                 d
    );
        logic [17:0] t;
        t = 18'(v) * 18'd10 + 18'(d);
        return t[dse_pkg::YEAR_W-1:0];
    endfunction

    assign role     = dse_pkg::role_of(format_mode, pos_reg);
    assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    assign digit    = is_digit ? char_byte[3:0] : 4'd0;
    assign len_ok   = format_mode ? (pos_reg == 5'(dse_pkg::LEN_LOCAL - 1))
                                  : (pos_reg == 5'(dse_pkg::LEN_GMT - 1));

    always_comb
    begin
        year_next    = year_reg;
        month_next   = month_reg;
        letters_next = letters_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        bad_next     = bad_reg;
        if (role == dse_pkg::ROLE_LETTER)
        begin
            letters_next = {letters_reg[15:0], char_byte};
        end
        else if (role != dse_pkg::ROLE_NONE)
        begin
            if (!is_digit)
            begin
                bad_next = 1'b1;
            end
            unique case (role)
                dse_pkg::ROLE_YEAR:  year_next   = mac14(year_reg, digit);
                dse_pkg::ROLE_MONTH: month_next  = mac7(month_reg, digit);
                dse_pkg::ROLE_DAY:   day_next    = mac7(day_reg, digit);
                dse_pkg::ROLE_HOUR:  hour_next   = mac7(hour_reg, digit);
                dse_pkg::ROLE_MIN:   minute_next = mac7(minute_reg, digit);
                default:             second_next = mac7(second_reg, digit);
            endcase
        end
    end

    assign q_push           = accept && is_last;
    assign q_data.mode      = format_mode;
    assign q_data.len_ok    = len_ok;
    assign q_data.bad       = bad_next;
    assign q_data.year      = year_next;
    assign q_data.month_val = month_next;
    assign q_data.letters   = letters_next;
    assign q_data.day       = day_next;
    assign q_data.hour      = hour_next;
    assign q_data.minute    = minute_next;
    assign q_data.second    = second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            year_reg    <= '0;
            month_reg   <= '0;
            letters_reg <= '0;
            day_reg     <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            bad_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                pos_reg     <= '0;
                year_reg    <= '0;
                month_reg   <= '0;
                letters_reg <= '0;
                day_reg     <= '0;
                hour_reg    <= '0;
                minute_reg  <= '0;
                second_reg  <= '0;
                bad_reg     <= 1'b0;
            end
            else
            begin
                if (pos_reg != 5'(dse_pkg::POS_MAX))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                year_reg    <= year_next;
                month_reg   <= month_next;
                letters_reg <= letters_next;
                day_reg     <= day_next;
                hour_reg    <= hour_next;
                minute_reg  <= minute_next;
                second_reg  <= second_next;
                bad_reg     <= bad_next;
            end
        end
    end

endmodule

// ----- hdl/dse_back.sv -----
// ----------------------------------------------------------------------------
// dse_back
// Validation and day-count sequencer with the result register.
// ----------------------------------------------------------------------------
`include "date_string_to_epoch_core_macros.svh"

module dse_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  dse_pkg::job_t                        q_data,
    output logic                                 q_pop,
    input  logic signed [dse_pkg::OFFSET_W-1:0]  utc_offset,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [dse_pkg::EPOCH_W-1:0]   epoch_seconds,
    output logic                                 valid_res
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_LEAP   = 9'b000000100,
        ST_DIV100 = 9'b000001000,
        ST_DIV400 = 9'b000010000,
        ST_SUM    = 9'b000100000,
        ST_MUL    = 9'b001000000,
        ST_ADD    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    localparam logic [15:0]        DIV25_MULT  = 16'd41944;
    localparam logic [24:0]        DAY_BIAS    = 25'd865596;
    localparam logic signed [17:0] DAY_SECONDS = 18'sd86400;

    state_t                               state_reg, state_next;
    dse_pkg::job_t                        job_reg;
    logic                                 pre_ok_reg;
    logic                                 day_ok_reg;
    logic                                 feb29_reg;
    logic                                 ok_reg;
    logic [3:0]                           m0_reg;
    logic [7:0]                           qy_reg;
    logic [14:0]                          y_reg;
    logic [3:0]                           mm_reg;
    logic [7:0]                           q100_reg;
    logic [7:0]                           q400_reg;
    logic [22:0]                          y365_reg;
    logic signed [24:0]                   days_reg;
    logic [16:0]                          tod_reg;
    logic [dse_pkg::EPOCH_W+1:0]          prod_reg;
    logic [dse_pkg::EPOCH_W-1:0]          secs_reg;
    logic                                 out_valid_reg;
    logic [dse_pkg::EPOCH_W-1:0]          epoch_reg;
    logic                                 res_ok_reg;

    logic                                 month_ok;
    logic [3:0]                           m0;
    logic                                 feb29;
    logic                                 leap_bad;
    logic                                 can_write;
    logic signed [42:0]                   prod_full;
    logic [dse_pkg::EPOCH_W-1:0]          offset_ext;

    // Quotient by 25 through a reciprocal; exact for inputs below 6400.
    function automatic logic [7:0] div25(input logic [12:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'(DIV25_MULT);
        return p[27:20];
    endfunction

    always_comb
    begin
        month_ok = 1'b1;
        m0       = 4'd0;
        if (job_reg.mode)
        begin
            month_ok = (job_reg.month_val >= 7'd1) && (job_reg.month_val <= 7'd12);
            m0       = 4'(job_reg.month_val - 7'd1);
        end
        else
        begin
            unique case (job_reg.letters[23:16])
                8'h4A:
                begin
                    if (job_reg.letters[15:8] == 8'h61)
                    begin
                        m0 = 4'd0;
                    end
                    else if (job_reg.letters[7:0] == 8'h6E)
                    begin
                        m0 = 4'd5;
                    end
                    else
                    begin
                        m0 = 4'd6;
                    end
                end
                8'h46: m0 = 4'd1;
                8'h4D: m0 = (job_reg.letters[7:0] == 8'h72) ? 4'd2 : 4'd4;
                8'h41: m0 = (job_reg.letters[15:8] == 8'h70) ? 4'd3 : 4'd7;
                8'h53: m0 = 4'd8;
                8'h4F: m0 = 4'd9;
                8'h4E: m0 = 4'd10;
                8'h44: m0 = 4'd11;
                default:
                begin
                    month_ok = 1'b0;
                    m0       = 4'd0;
                end
            endcase
        end
    end

    assign feb29      = (job_reg.day == 7'd29) && (m0 == 4'd1);
    assign leap_bad   = (job_reg.year[1:0] != 2'd0) ||
                        (({1'b0, job_reg.year} == 15'(qy_reg) * 15'd100) &&
                         (qy_reg[1:0] != 2'd0));
    assign can_write  = !out_valid_reg || pop;
    assign prod_full  = days_reg * DAY_SECONDS;
    assign offset_ext = {{(dse_pkg::EPOCH_W - dse_pkg::OFFSET_W){utc_offset[16]}},
                         utc_offset};
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_LEAP;
            ST_LEAP:   state_next = ST_DIV100;
            ST_DIV100: state_next = ST_DIV400;
            ST_DIV400: state_next = ST_SUM;
            ST_SUM:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_DONE;
            ST_DONE:   if (can_write) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_DONE) && can_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg <= q_data;
                end
            end
            ST_CHECK:
            begin
                pre_ok_reg <= !job_reg.bad && job_reg.len_ok && month_ok &&
                              (job_reg.hour <= 7'd23) && (job_reg.minute <= 7'd59) &&
                              (job_reg.second <= 7'd59);
                day_ok_reg <= feb29 || (job_reg.day <= dse_pkg::days_in_month(m0));
                feb29_reg  <= feb29;
                m0_reg     <= m0;
                qy_reg     <= div25({1'b0, job_reg.year[13:2]});
            end
            ST_LEAP:
            begin
                ok_reg <= pre_ok_reg && day_ok_reg && !(feb29_reg && leap_bad);
                if (m0_reg <= 4'd1)
                begin
                    y_reg  <= 15'(job_reg.year) + 15'd399;
                    mm_reg <= m0_reg + 4'd11;
                end
                else
                begin
                    y_reg  <= 15'(job_reg.year) + 15'd400;
                    mm_reg <= m0_reg - 4'd1;
                end
            end
            ST_DIV100:
            begin
                q100_reg <= div25(y_reg[14:2]);
            end
            ST_DIV400:
            begin
                q400_reg <= div25({2'b00, y_reg[14:4]});
                y365_reg <= 23'(y_reg) * 23'd365;
            end
            ST_SUM:
            begin
                days_reg <= $signed(25'(y365_reg) + 25'(y_reg[14:2]) - 25'(q100_reg) +
                                    25'(q400_reg) + 25'(dse_pkg::month_days_367(mm_reg)) +
                                    25'(job_reg.day) - DAY_BIAS);
                tod_reg  <= 17'(17'(job_reg.hour) * 17'd3600 +
                                17'(job_reg.minute) * 17'd60 + 17'(job_reg.second));
            end
            ST_MUL:
            begin
                prod_reg <= prod_full[dse_pkg::EPOCH_W+1:0];
            end
            ST_ADD:
            begin
                secs_reg <= prod_reg[dse_pkg::EPOCH_W-1:0] + dse_pkg::EPOCH_W'(tod_reg) -
                            (job_reg.mode ? offset_ext : '0);
            end
            ST_DONE:
            begin
                if (can_write)
                begin
                    epoch_reg  <= ok_reg ? secs_reg : '0;
                    res_ok_reg <= ok_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign empty         = !out_valid_reg;
    assign epoch_seconds = $signed(epoch_reg);
    assign valid_res     = res_ok_reg;

    `DSE_ASSERT_SAME(a_invalid_is_zero, clk, rst_n, out_valid_reg && !res_ok_reg, epoch_reg == '0)
    `DSE_ASSERT_SAME(a_pop_only_idle, clk, rst_n, q_pop, state_reg == ST_IDLE)
    `DSE_ASSERT_NEXT(a_done_waits, clk, rst_n, (state_reg == ST_DONE) && out_valid_reg && !pop, state_reg == ST_DONE)

endmodule
